FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset
`define ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Default clock and reset of the project
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Types, constants and digit helpers of the countdown timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int unsigned DIGITS    = 4;
  localparam int unsigned ScanW     = $clog2(DIGITS);
  localparam int unsigned SecsW     = 13;
  localparam int unsigned MsW       = 10;
  localparam int unsigned ElapsedSW = 14;

  localparam logic [SecsW-1:0]     PRESET_MAX     = 13'd5999;
  localparam logic [MsW-1:0]       MS_LAST        = 10'd999;
  localparam logic [MsW-1:0]       MS_PER_S       = 10'd1000;
  localparam logic [ElapsedSW-1:0] ELAPSED_MAX_S  = 14'd8388;
  localparam logic [MsW-1:0]       ELAPSED_MAX_MS = 10'd607;
  localparam logic [7:0]           SEG_BLANK      = 8'hFF;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_REFRESH   = 3'd1,
    OP_LOAD      = 3'd2,
    OP_START     = 3'd3,
    OP_STOP      = 3'd4,
    OP_CLR_ALARM = 3'd5,
    OP_BLINK_ON  = 3'd6,
    OP_BLINK_OFF = 3'd7
  } op_e;

  typedef enum logic {
    REG_PRESET = 1'b0,
    REG_MODE   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [SecsW-1:0] preset;
    logic             mode;
  } cfg_t;

  typedef struct packed {
    logic [SecsW-1:0] secs;
    logic [MsW-1:0]   ms;
    logic             colon;
  } disp_src_t;

  typedef struct packed {
    logic             alarm;
    logic             running;
    logic [SecsW-1:0] secs;
  } status_t;

  // floor(x / 60) for x below 7680
  function automatic logic [6:0] div60(input logic [SecsW-1:0] x);
    logic [26:0] prod;
    prod = x * 14'd8739;
    return prod[25:19];
  endfunction

  // floor(x / 10) for x below 1024
  function automatic logic [6:0] div10(input logic [MsW-1:0] x);
    logic [17:0] prod;
    prod = x * 8'd205;
    return prod[17:11];
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/cdt_apb_regs.sv
// ----------------------------------------------------------------------------
// cdt_apb_regs
// APB register file: countdown preset and display mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdt_apb_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cdt_pkg::cfg_t cfg_o
);
  import cdt_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_PRESET: cfg_d.preset = pwdata[SecsW-1:0];
        REG_MODE:   cfg_d.mode   = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PRESET: prdata = {{(32-SecsW){1'b0}}, cfg_q.preset};
      REG_MODE:   prdata = {31'd0, cfg_q.mode};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/cdt_timer.sv
// ----------------------------------------------------------------------------
// cdt_timer
// Countdown, alarm, run and colon blink state, updated once per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdt_timer #(
  parameter int unsigned BLINK_HALF_MS = 500
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  cdt_pkg::op_e                op_i,
  input  logic                        colon_final_i,
  input  logic [cdt_pkg::SecsW-1:0]   preset_i,
  output cdt_pkg::disp_src_t          disp_o,
  output cdt_pkg::status_t            status_o
);
  import cdt_pkg::*;

  localparam int unsigned BlinkW = $clog2(BLINK_HALF_MS + 2);
  localparam logic [BlinkW-1:0] BlinkHalf = BlinkW'(BLINK_HALF_MS);

  logic [ElapsedSW-1:0] es_q, es_d;
  logic [MsW-1:0]       ef_q, ef_d;
  logic [SecsW-1:0]     load_q, load_d;
  logic [SecsW-1:0]     secs_q, secs_d;
  logic [MsW-1:0]       ms_q, ms_d;
  logic                 run_q, run_d;
  logic                 alarm_q, alarm_d;
  logic                 blink_q, blink_d;
  logic                 colon_q, colon_d;
  logic [BlinkW-1:0]    bc_q, bc_d;

  logic [ElapsedSW-1:0] es_n;
  logic [MsW-1:0]       ef_n;
  logic                 ef_nz;
  logic                 expired;
  logic [ElapsedSW-1:0] diff;
  logic [BlinkW-1:0]    bc_inc;
  logic [SecsW-1:0]     preset_sat;

  always_comb begin
    es_n = es_q;
    ef_n = ef_q;
    if (!(es_q == ELAPSED_MAX_S && ef_q == ELAPSED_MAX_MS)) begin
      if (ef_q == MS_LAST) begin
        ef_n = '0;
        es_n = es_q + 1'b1;
      end else begin
        ef_n = ef_q + 1'b1;
      end
    end
    ef_nz   = (ef_n != '0);
    expired = (es_n > {1'b0, load_q}) || ((es_n == {1'b0, load_q}) && ef_nz);
    diff    = {1'b0, load_q} - es_n - {{(ElapsedSW-1){1'b0}}, ef_nz};
    bc_inc  = bc_q + 1'b1;
    preset_sat = (preset_i > PRESET_MAX) ? PRESET_MAX : preset_i;
  end

  always_comb begin
    es_d    = es_q;
    ef_d    = ef_q;
    load_d  = load_q;
    secs_d  = secs_q;
    ms_d    = ms_q;
    run_d   = run_q;
    alarm_d = alarm_q;
    blink_d = blink_q;
    colon_d = colon_q;
    bc_d    = bc_q;
    if (accept_i) begin
      unique case (op_i)
        OP_TICK: begin
          if (blink_q) begin
            if (bc_inc > BlinkHalf) begin
              colon_d = ~colon_q;
              bc_d    = bc_inc - BlinkHalf;
            end else begin
              bc_d = bc_inc;
            end
          end
          if (run_q) begin
            es_d = es_n;
            ef_d = ef_n;
            if (expired) begin
              secs_d  = '0;
              ms_d    = '0;
              run_d   = 1'b0;
              alarm_d = 1'b1;
            end else begin
              secs_d = diff[SecsW-1:0];
              ms_d   = ef_nz ? (MS_PER_S - ef_n) : '0;
            end
          end
        end
        OP_REFRESH: begin
        end
        OP_LOAD: begin
          load_d  = preset_sat;
          secs_d  = preset_sat;
          ms_d    = '0;
          alarm_d = 1'b0;
        end
        OP_START: begin
          run_d  = 1'b1;
          es_d   = '0;
          ef_d   = '0;
          bc_d   = '0;
          secs_d = load_q;
          ms_d   = '0;
        end
        OP_STOP:      run_d   = 1'b0;
        OP_CLR_ALARM: alarm_d = 1'b0;
        OP_BLINK_ON:  blink_d = 1'b1;
        OP_BLINK_OFF: begin
          blink_d = 1'b0;
          colon_d = colon_final_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q    <= '0;
      ef_q    <= '0;
      load_q  <= '0;
      secs_q  <= '0;
      ms_q    <= '0;
      run_q   <= 1'b0;
      alarm_q <= 1'b0;
      blink_q <= 1'b0;
      colon_q <= 1'b0;
      bc_q    <= '0;
    end else begin
      es_q    <= es_d;
      ef_q    <= ef_d;
      load_q  <= load_d;
      secs_q  <= secs_d;
      ms_q    <= ms_d;
      run_q   <= run_d;
      alarm_q <= alarm_d;
      blink_q <= blink_d;
      colon_q <= colon_d;
      bc_q    <= bc_d;
    end
  end

  assign disp_o   = '{secs: secs_q, ms: ms_q, colon: colon_q};
  assign status_o = '{alarm: alarm_d, running: run_d, secs: secs_d};

endmodule

FILE: rtl/cdt_display.sv
// ----------------------------------------------------------------------------
// cdt_display
// Digit extraction, scan position and latched active-low segment pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdt_display (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        refresh_i,
  input  logic                        mode_i,
  input  cdt_pkg::disp_src_t          disp_i,
  output logic [7:0]                  seg_n_o,
  output logic [cdt_pkg::DIGITS-1:0]  digit_en_o
);
  import cdt_pkg::*;

  logic [ScanW-1:0] scan_q, scan_d;
  logic [7:0]       latch_q, latch_d;

  logic [6:0]  mins, sp, hp, t0, t1, u0, u1;
  logic [12:0] mins60;
  logic [3:0]  dig;
  logic [ScanW-1:0] last;

  always_comb begin
    mins   = div60(disp_i.secs);
    mins60 = {mins, 6'd0} - {4'd0, mins, 2'd0};
    sp     = disp_i.secs[6:0] - mins60[6:0];
    hp     = div10(disp_i.ms);
    if (mode_i) begin
      u0 = sp;
      u1 = hp;
    end else begin
      u0 = mins;
      u1 = sp;
    end
    t0 = div10({3'd0, u0});
    t1 = div10({3'd0, u1});
    unique case (scan_q)
      2'd0:    dig = t0[3:0];
      2'd1:    dig = 4'(u0 - (t0 * 7'd10));
      2'd2:    dig = t1[3:0];
      default: dig = 4'(u1 - (t1 * 7'd10));
    endcase
  end

  always_comb begin
    scan_d  = scan_q;
    latch_d = latch_q;
    if (refresh_i) begin
      latch_d = ~{disp_i.colon, seg_of(dig)};
      scan_d  = scan_q + 1'b1;
    end
    last = scan_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      latch_q <= SEG_BLANK;
    end else begin
      scan_q  <= scan_d;
      latch_q <= latch_d;
    end
  end

  assign seg_n_o    = latch_d;
  assign digit_en_o = (latch_d == SEG_BLANK) ? '0 : (DIGITS'(1) << last);

endmodule

FILE: rtl/countdown_timer_seven_segment.sv
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment: ms countdown timer with 4-digit 7-seg display
// Result: valid in the cycle after the item is taken (output register).
// Throughput: 1 item per cycle unless out_ready_i stalls; state and result registers update together.
// Reset: asynchronous, clears all state; segments blank, digit enable zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_seven_segment #(
  parameter int unsigned BLINK_HALF_MS = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic        colon_final_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  segments_n_o,
  output logic [3:0]  digit_enable_o,
  output logic        alarm_o,
  output logic        running_o,
  output logic [12:0] seconds_left_o
);
  import cdt_pkg::*;

  cfg_t      cfg;
  disp_src_t disp;
  status_t   status;
  op_e       op;
  logic      accept;
  logic      refresh;

  logic [7:0]        seg_d, seg_q;
  logic [DIGITS-1:0] den_d, den_q;
  status_t           stat_q;
  logic              ov_q, ov_d;

  assign op         = op_e'(operation_i);
  assign in_ready_o = ~ov_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign refresh    = accept & (op == OP_REFRESH);

  cdt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cdt_timer #(
    .BLINK_HALF_MS (BLINK_HALF_MS)
  ) u_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op),
    .colon_final_i (colon_final_i),
    .preset_i      (cfg.preset),
    .disp_o        (disp),
    .status_o      (status)
  );

  cdt_display u_disp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .refresh_i  (refresh),
    .mode_i     (cfg.mode),
    .disp_i     (disp),
    .seg_n_o    (seg_d),
    .digit_en_o (den_d)
  );

  always_comb begin
    ov_d = ov_q;
    if (accept) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= SEG_BLANK;
      den_q  <= '0;
      stat_q <= '0;
    end else if (accept) begin
      seg_q  <= seg_d;
      den_q  <= den_d;
      stat_q <= status;
    end
  end

  assign out_valid_o    = ov_q;
  assign segments_n_o   = seg_q;
  assign digit_enable_o = den_q;
  assign alarm_o        = stat_q.alarm;
  assign running_o      = stat_q.running;
  assign seconds_left_o = stat_q.secs;

endmodule

FILE: rtl/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks of the countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  segments_n_o,
  input logic [3:0]  digit_enable_o,
  input logic [12:0] seconds_left_o
);

  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(segments_n_o), "result dropped or changed while stalled")
  `ASSERT_DEF(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `ASSERT_DEF(a_digit_onehot, out_valid_o |-> $onehot0(digit_enable_o), "digit enable not one-hot")
  `ASSERT_DEF(a_blank_no_digit, out_valid_o |-> ((digit_enable_o == 4'd0) == (segments_n_o == 8'hFF)), "digit enable disagrees with blank latch")
  `ASSERT_DEF(a_secs_range, out_valid_o |-> (seconds_left_o <= 13'd5999), "seconds left above preset limit")

endmodule

bind countdown_timer_seven_segment cdt_checker u_cdt_checker (.*);

FILE: sim/countdown_timer_seven_segment_tb.sv
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment_tb: self-checking bench of the countdown timer
// Operations go in through a valid/ready driver and results are checked by a
// monitor against a cycle-free model of timer, blink and display scan. Short
// directed sequences open the run, then random phases follow, each with a
// fresh preset and display mode written over APB once the queue has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_seven_segment_tb;
  import cdt_pkg::*;

  localparam int unsigned BLINK_HALF   = 500;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam logic [22:0] SINCE_SAT    = 23'h7FFFFF;
  localparam logic [69:0] DIGIT_SEGS   = {7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                          7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    op_e  op;
    logic fin;
  } op_item_t;

  typedef struct packed {
    logic [7:0]  segs;
    logic [3:0]  digits;
    logic        alarm;
    logic        running;
    logic [12:0] secs;
  } disp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i   = '0;
  logic        colon_final_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  segments_n_o;
  logic [3:0]  digit_enable_o;
  logic        alarm_o;
  logic        running_o;
  logic [12:0] seconds_left_o;

  countdown_timer_seven_segment #(
    .BLINK_HALF_MS(BLINK_HALF)
  ) i_dut (.*);

  op_item_t    pending_q[$];
  disp_t       display_q[$];
  int unsigned queued_cnt  = 0;
  int unsigned checked_cnt = 0;
  int unsigned err_cnt     = 0;
  int unsigned stall_cnt   = 0;
  logic        in_fire     = 1'b0;
  logic        out_fire    = 1'b0;
  logic        calm        = 1'b0;

  logic [12:0] cfg_preset;
  logic        cfg_mode;
  logic [22:0] since_start_ms;
  logic [22:0] remain_ms;
  logic [22:0] span_ms;
  logic        counting;
  logic        alarm_up;
  logic        blinking;
  logic        colon_lit;
  logic [9:0]  blink_phase;
  logic [1:0]  next_digit;
  logic [7:0]  seg_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic step_timer(input op_e op, input logic fin, output disp_t res);
    int unsigned secs;
    int unsigned mins;
    int unsigned sec_part;
    int unsigned hund;
    int unsigned lim;
    int unsigned dg[4];
    case (op)
      OP_TICK: begin
        if (blinking) begin
          blink_phase = blink_phase + 10'd1;
          if (blink_phase > BLINK_HALF) begin
            colon_lit   = !colon_lit;
            blink_phase = blink_phase - 10'(BLINK_HALF);
          end
        end
        if (counting) begin
          if (since_start_ms < SINCE_SAT) since_start_ms = since_start_ms + 23'd1;
          if (since_start_ms > span_ms) begin
            remain_ms = '0;
            counting  = 1'b0;
            alarm_up  = 1'b1;
          end else begin
            remain_ms = span_ms - since_start_ms;
          end
        end
      end
      OP_REFRESH: begin
        secs     = remain_ms / 1000;
        mins     = secs / 60;
        sec_part = secs % 60;
        hund     = (remain_ms / 10) % 100;
        if (cfg_mode == 1'b0) begin
          dg[0] = (mins / 10) % 10;
          dg[1] = mins % 10;
          dg[2] = sec_part / 10;
          dg[3] = sec_part % 10;
        end else begin
          dg[0] = sec_part / 10;
          dg[1] = sec_part % 10;
          dg[2] = hund / 10;
          dg[3] = hund % 10;
        end
        seg_hold   = ~{colon_lit, DIGIT_SEGS[dg[next_digit]*7 +: 7]};
        next_digit = next_digit + 2'd1;
      end
      OP_LOAD: begin
        lim       = (cfg_preset > PRESET_MAX) ? PRESET_MAX : cfg_preset;
        span_ms   = 23'(lim * 1000);
        remain_ms = span_ms;
        alarm_up  = 1'b0;
      end
      OP_START: begin
        counting       = 1'b1;
        since_start_ms = '0;
        blink_phase    = '0;
        remain_ms      = span_ms;
      end
      OP_STOP:      counting = 1'b0;
      OP_CLR_ALARM: alarm_up = 1'b0;
      OP_BLINK_ON:  blinking = 1'b1;
      default: begin
        blinking  = 1'b0;
        colon_lit = fin;
      end
    endcase
    res.segs    = seg_hold;
    res.digits  = (seg_hold == SEG_BLANK) ? 4'd0 : 4'd1 << (next_digit - 2'd1);
    res.alarm   = alarm_up;
    res.running = counting;
    res.secs    = 13'(remain_ms / 1000);
  endtask

  always @(negedge clk_i) begin : drv
    op_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          nxt = pending_q.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= nxt.op;
          colon_final_i <= nxt.fin;
        end else begin
          in_valid_i    <= 1'b0;
          operation_i   <= 3'($urandom_range(7));
          colon_final_i <= 1'($urandom_range(1));
        end
      end
      out_ready_i <= calm || $urandom_range(99) >= 30;
    end
  end

  always @(posedge clk_i) begin : mon
    disp_t want;
    disp_t got;
    disp_t pred;
    if (rst_ni) begin
      in_fire  = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      got = '{segments_n_o, digit_enable_o, alarm_o, running_o, seconds_left_o};
      if (out_fire) begin
        if (display_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result seg %h dig %h alarm %b run %b secs %0d",
                     $realtime, got.segs, got.digits, got.alarm, got.running, got.secs);
        end else begin
          want = display_q.pop_front();
          checked_cnt++;
          if (got.segs !== want.segs || got.digits !== want.digits ||
              got.alarm !== want.alarm || got.running !== want.running ||
              got.secs !== want.secs) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch seg %h/%h dig %h/%h alarm %b/%b run %b/%b secs %0d/%0d",
                       $realtime, want.segs, got.segs, want.digits, got.digits,
                       want.alarm, got.alarm, want.running, got.running,
                       want.secs, got.secs);
          end
        end
      end
      if (in_fire) begin
        step_timer(op_e'(operation_i), colon_final_i, pred);
        display_q.push_back(pred);
      end
      if (in_fire || out_fire) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic queue_op(input op_e op, input logic fin);
    pending_q.push_back('{op, fin});
    queued_cnt++;
  endtask

  function automatic op_e rand_op(input int unsigned tick_pct, input int unsigned misc_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < tick_pct) return OP_TICK;
    if (r < tick_pct + misc_pct) return op_e'($urandom_range(2, 7));
    return OP_REFRESH;
  endfunction

  task automatic drain();
    while (checked_cnt != queued_cnt) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PRESET) cfg_preset = val[12:0];
    else cfg_mode = val[0];
  endtask

  task automatic set_config(input logic [12:0] preset, input logic mode);
    drain();
    reg_write(REG_PRESET, {19'($urandom()), preset});
    reg_write(REG_MODE, {31'($urandom()), mode});
  endtask

  initial begin : stim
    int unsigned rand_cnt;
    int unsigned len;
    logic [12:0] preset;
    cfg_preset     = '0;
    cfg_mode       = 1'b0;
    since_start_ms = '0;
    remain_ms      = '0;
    span_ms        = '0;
    counting       = 1'b0;
    alarm_up       = 1'b0;
    blinking       = 1'b0;
    colon_lit      = 1'b0;
    blink_phase    = '0;
    next_digit     = '0;
    seg_hold       = SEG_BLANK;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_op(OP_TICK, 1'b0);
    queue_op(OP_STOP, 1'b1);
    queue_op(OP_CLR_ALARM, 1'b0);
    queue_op(OP_BLINK_OFF, 1'b1);
    repeat (5) queue_op(OP_REFRESH, 1'b0);
    queue_op(OP_LOAD, 1'b0);
    queue_op(OP_START, 1'b1);
    queue_op(OP_TICK, 1'b0);
    queue_op(OP_CLR_ALARM, 1'b1);
    queue_op(OP_BLINK_ON, 1'b0);
    queue_op(OP_TICK, 1'b1);
    queue_op(OP_BLINK_OFF, 1'b0);
    queue_op(OP_REFRESH, 1'b1);
    set_config(13'h1FFF, 1'b1);
    queue_op(OP_LOAD, 1'b1);
    queue_op(OP_REFRESH, 1'b0);
    queue_op(OP_REFRESH, 1'b0);
    queue_op(OP_START, 1'b0);
    queue_op(OP_TICK, 1'b0);
    queue_op(OP_TICK, 1'b1);
    queue_op(OP_LOAD, 1'b0);
    queue_op(OP_TICK, 1'b0);
    queue_op(OP_REFRESH, 1'b1);
    queue_op(OP_STOP, 1'b0);

    rand_cnt = 0;
    set_config(13'd1, 1'($urandom_range(1)));
    queue_op(OP_LOAD, 1'($urandom_range(1)));
    queue_op(OP_BLINK_ON, 1'($urandom_range(1)));
    queue_op(OP_START, 1'($urandom_range(1)));
    repeat (1350) queue_op(rand_op(80, 0), 1'($urandom_range(1)));
    rand_cnt += 1353;

    while (rand_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       preset = 13'd0;
        1:       preset = 13'd1;
        2:       preset = 13'($urandom_range(5999));
        3:       preset = PRESET_MAX;
        4:       preset = 13'($urandom_range(8191, 6000));
        default: preset = 13'h1FFF;
      endcase
      set_config(preset, 1'($urandom_range(1)));
      calm = (rand_cnt == 1353);
      len  = $urandom_range(160, 60);
      queue_op(OP_LOAD, 1'($urandom_range(1)));
      repeat (len) queue_op(rand_op(45, 20), 1'($urandom_range(1)));
      rand_cnt += len + 1;
    end

    drain();
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && display_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: countdown_timer_seven_segment.f
+incdir+rtl
rtl/cdt_pkg.sv
rtl/cdt_apb_regs.sv
rtl/cdt_timer.sv
rtl/cdt_display.sv
rtl/countdown_timer_seven_segment.sv
rtl/cdt_checker.sv
sim/countdown_timer_seven_segment_tb.sv
